FILE: hw/rtl/swfc_pkg.sv
// ----------------------------------------------------------------------------
// swfc_pkg
// Shared types and constants for the stopwatch with framed commands.
// ----------------------------------------------------------------------------
package swfc_pkg;

   // field widths
   localparam int unsigned HOURS_W   = 8;
   localparam int unsigned MINSEC_W  = 6;
   localparam int unsigned MODE_W    = 2;
   localparam int unsigned KIND_W    = 3;
   localparam int unsigned BYTE_W    = 8;
   localparam int unsigned CSR_IDX_W = 8;
   localparam int unsigned CSR_DAT_W = 8;

   // frame guard length in bytes
   localparam logic [BYTE_W-1:0] FRAME_MAX = 8'd16;

   // time limits
   localparam logic [MINSEC_W-1:0] MINSEC_LAST = 6'd59;

   // request kinds
   localparam logic [KIND_W-1:0] KIND_TICK      = 3'd0;
   localparam logic [KIND_W-1:0] KIND_CONSOLE   = 3'd1;
   localparam logic [KIND_W-1:0] KIND_FRAME     = 3'd2;
   localparam logic [KIND_W-1:0] KIND_RESET_BTN = 3'd3;
   localparam logic [KIND_W-1:0] KIND_DOWN_BTN  = 3'd4;

   // count modes
   localparam logic [MODE_W-1:0] MODE_UP   = 2'd0;
   localparam logic [MODE_W-1:0] MODE_DOWN = 2'd1;
   localparam logic [MODE_W-1:0] MODE_STOP = 2'd2;

   // command bytes
   localparam logic [BYTE_W-1:0] CMD_CLEAR  = 8'h72;  // 'r'
   localparam logic [BYTE_W-1:0] CMD_DOWN   = 8'h64;  // 'd'
   localparam logic [BYTE_W-1:0] CMD_LED    = 8'h76;  // 'v'

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_CD_MINUTES = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CD_SECONDS = 8'd1;

   typedef struct packed {
      logic [KIND_W-1:0] req_type;
      logic [BYTE_W-1:0] data_byte;
   } req_payload_type;

   typedef struct packed {
      logic [HOURS_W-1:0]  hours;
      logic [MINSEC_W-1:0] minutes;
      logic [MINSEC_W-1:0] seconds;
      logic [MODE_W-1:0]   count_mode;
      logic                tick_led;
      logic                command_led;
      logic                frame_done;
   } rsp_payload_type;

   // countdown preset as held by the register block
   typedef struct packed {
      logic [MINSEC_W-1:0] minutes;
      logic [MINSEC_W-1:0] seconds;
   } preset_type;

endpackage

FILE: hw/rtl/swfc_csr.sv
// ----------------------------------------------------------------------------
// swfc_csr
// Countdown preset registers written through the configuration port.
// ----------------------------------------------------------------------------
module swfc_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [swfc_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [swfc_pkg::CSR_DAT_W-1:0]     csr_wdata,
   output swfc_pkg::preset_type               preset
);

   swfc_pkg::preset_type preset_ff;
   swfc_pkg::preset_type preset_in;

   // always ready; each write lands in the preset register
   assign csr_ready = 1'b1;

   // index decode
   always_comb begin
      preset_in = preset_ff;
      if (csr_valid) begin
         unique case (csr_index)
            swfc_pkg::CSR_CD_MINUTES: preset_in.minutes = csr_wdata[swfc_pkg::MINSEC_W-1:0];
            swfc_pkg::CSR_CD_SECONDS: preset_in.seconds = csr_wdata[swfc_pkg::MINSEC_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         preset_ff.minutes <= 6'd2;
         preset_ff.seconds <= 6'd59;
      end else begin
         preset_ff <= preset_in;
      end
   end

   assign preset = preset_ff;

endmodule

FILE: hw/rtl/swfc_engine.sv
// ----------------------------------------------------------------------------
// swfc_engine
// Stopwatch state and the update it makes for each event.
// ----------------------------------------------------------------------------
module swfc_engine (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      fire,
   input  swfc_pkg::req_payload_type item,
   input  swfc_pkg::preset_type      preset,
   output swfc_pkg::rsp_payload_type result
);

   typedef struct packed {
      logic [swfc_pkg::HOURS_W-1:0]  hour_count;
      logic [swfc_pkg::MINSEC_W-1:0] minute_count;
      logic [swfc_pkg::MINSEC_W-1:0] second_count;
      logic [swfc_pkg::MODE_W-1:0]   mode;
      logic                          tick_led_level;
      logic                          command_led_level;
      logic                          frame_active;
      logic [swfc_pkg::BYTE_W-1:0]   frame_count;
      logic [swfc_pkg::BYTE_W-1:0]   frame_length;
      logic [swfc_pkg::BYTE_W-1:0]   frame_command;
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic [swfc_pkg::MINSEC_W-1:0] load_min;
   logic [swfc_pkg::MINSEC_W-1:0] load_sec;
   logic [swfc_pkg::BYTE_W-1:0]   cnt_next;
   logic [swfc_pkg::BYTE_W-1:0]   cmd_next;
   logic                          done;

   // clamped countdown preset
   assign load_min = (preset.minutes > swfc_pkg::MINSEC_LAST) ? swfc_pkg::MINSEC_LAST
                                                             : preset.minutes;
   assign load_sec = (preset.seconds > swfc_pkg::MINSEC_LAST) ? swfc_pkg::MINSEC_LAST
                                                             : preset.seconds;

   // frame byte bookkeeping
   assign cnt_next = state_ff.frame_count + 8'd1;
   assign cmd_next = (state_ff.frame_count == 8'd2) ? item.data_byte : state_ff.frame_command;

   // next state for one event
   always_comb begin
      state_in = state_ff;
      done     = 1'b0;
      unique case (item.req_type)
         swfc_pkg::KIND_TICK: begin
            state_in.tick_led_level = ~state_ff.tick_led_level;
            if (state_ff.mode == swfc_pkg::MODE_UP) begin
               if (state_ff.second_count >= swfc_pkg::MINSEC_LAST) begin
                  state_in.second_count = '0;
                  if (state_ff.minute_count >= swfc_pkg::MINSEC_LAST) begin
                     state_in.minute_count = '0;
                     state_in.hour_count   = state_ff.hour_count + 8'd1;
                  end else begin
                     state_in.minute_count = state_ff.minute_count + 6'd1;
                  end
               end else begin
                  state_in.second_count = state_ff.second_count + 6'd1;
               end
            end else if (state_ff.mode == swfc_pkg::MODE_DOWN) begin
               if (state_ff.second_count != '0) begin
                  state_in.second_count = state_ff.second_count - 6'd1;
               end else if (state_ff.minute_count != '0) begin
                  state_in.minute_count = state_ff.minute_count - 6'd1;
                  state_in.second_count = swfc_pkg::MINSEC_LAST;
               end
               if (state_in.minute_count == '0 && state_in.second_count == '0) begin
                  state_in.mode = swfc_pkg::MODE_STOP;
               end
            end
         end
         swfc_pkg::KIND_CONSOLE: begin
            if (item.data_byte == swfc_pkg::CMD_LED) begin
               state_in.command_led_level = ~state_ff.command_led_level;
            end else if (item.data_byte == swfc_pkg::CMD_CLEAR) begin
               state_in.hour_count   = '0;
               state_in.minute_count = '0;
               state_in.second_count = '0;
               state_in.mode         = swfc_pkg::MODE_UP;
            end else if (item.data_byte == swfc_pkg::CMD_DOWN) begin
               state_in.hour_count   = '0;
               state_in.minute_count = load_min;
               state_in.second_count = load_sec;
               state_in.mode         = swfc_pkg::MODE_DOWN;
            end
         end
         swfc_pkg::KIND_FRAME: begin
            if (!state_ff.frame_active) begin
               // opening byte, value ignored
               state_in.frame_active = 1'b1;
               state_in.frame_count  = 8'd1;
            end else if (state_ff.frame_count == 8'd1) begin
               state_in.frame_length = item.data_byte;
               state_in.frame_count  = 8'd2;
            end else begin
               state_in.frame_command = cmd_next;
               state_in.frame_count   = cnt_next;
               if (cnt_next == state_ff.frame_length || cnt_next >= swfc_pkg::FRAME_MAX) begin
                  done                  = 1'b1;
                  state_in.frame_active = 1'b0;
                  state_in.frame_count  = '0;
                  if (cmd_next == swfc_pkg::CMD_CLEAR) begin
                     state_in.hour_count   = '0;
                     state_in.minute_count = '0;
                     state_in.second_count = '0;
                     state_in.mode         = swfc_pkg::MODE_UP;
                  end else if (cmd_next == swfc_pkg::CMD_DOWN) begin
                     state_in.hour_count   = '0;
                     state_in.minute_count = load_min;
                     state_in.second_count = load_sec;
                     state_in.mode         = swfc_pkg::MODE_DOWN;
                  end
               end
            end
         end
         swfc_pkg::KIND_RESET_BTN: begin
            state_in.hour_count   = '0;
            state_in.minute_count = '0;
            state_in.second_count = '0;
            state_in.mode         = swfc_pkg::MODE_UP;
         end
         swfc_pkg::KIND_DOWN_BTN: begin
            state_in.hour_count   = '0;
            state_in.minute_count = load_min;
            state_in.second_count = load_sec;
            state_in.mode         = swfc_pkg::MODE_DOWN;
         end
         default: ;
      endcase
   end

   // state register, moves only when an event is processed
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else if (fire) begin
         state_ff <= state_in;
      end
   end

   // result reflects the state after the event
   always_comb begin
      result.hours       = state_in.hour_count;
      result.minutes     = state_in.minute_count;
      result.seconds     = state_in.second_count;
      result.count_mode  = state_in.mode;
      result.tick_led    = state_in.tick_led_level;
      result.command_led = state_in.command_led_level;
      result.frame_done  = done;
   end

endmodule

FILE: hw/rtl/stopwatch_with_framed_commands.sv
// ----------------------------------------------------------------------------
// stopwatch_with_framed_commands
// hh:mm:ss up/down stopwatch driven by ticks, console bytes, frames, buttons.
// ----------------------------------------------------------------------------
// Usage
//   req channel: one event per transfer (req_valid, req_stall, req_data).
//     req_type selects tick, console byte, frame byte, reset button or
//     countdown button; data_byte carries the received byte.
//   rsp channel: exactly one result per event (rsp_valid, rsp_stall,
//     rsp_data), in event order, showing the time, mode and LEDs after it.
//   csr channel: preset writes (csr_valid, csr_ready, csr_index, csr_wdata);
//     index 0 sets countdown minutes, index 1 countdown seconds. Always
//     ready, one write per cycle; write only while no event is in flight.
// Timing
//   An event lands in the input register on transfer, is processed from
//   there once the result side is not stalled, and its result is registered.
//   Throughput is one event per cycle unless rsp_stall holds a result;
//   the time/frame update is combinational into state and result registers.
// Reset and stalls
//   Synchronous reset clears time, mode, LEDs and framing, and sets the
//   preset to 02:59. While rsp_stall holds a result, one more event can be
//   taken into the input register; req_stall rises once that is full too.
// ----------------------------------------------------------------------------
module stopwatch_with_framed_commands (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  swfc_pkg::req_payload_type      req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output swfc_pkg::rsp_payload_type      rsp_data,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [swfc_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [swfc_pkg::CSR_DAT_W-1:0] csr_wdata
);

   logic                      in_valid_ff;
   logic                      in_valid_in;
   swfc_pkg::req_payload_type in_data_ff;
   logic                      rsp_valid_ff;
   logic                      rsp_valid_in;
   swfc_pkg::rsp_payload_type rsp_data_ff;
   swfc_pkg::rsp_payload_type result;
   swfc_pkg::preset_type      preset;
   logic                      advance;
   logic                      fire;

   // pipeline control
   assign advance     = !rsp_valid_ff || !rsp_stall;
   assign fire        = in_valid_ff && advance;
   assign req_stall   = in_valid_ff && !advance;
   assign in_valid_in = req_stall ? in_valid_ff : req_valid;
   assign rsp_valid_in = advance ? fire : rsp_valid_ff;

   // input and result registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall) begin
         in_data_ff <= req_data;
      end
      if (fire) begin
         rsp_data_ff <= result;
      end
   end

   swfc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .preset    (preset)
   );

   swfc_engine u_engine (
      .clock  (clock),
      .reset  (reset),
      .fire   (fire),
      .item   (in_data_ff),
      .preset (preset),
      .result (result)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

FILE: hw/rtl/swfc_checker.sv
// ----------------------------------------------------------------------------
// swfc_checker
// Port-level checks on the stopwatch, bound to the top level.
// ----------------------------------------------------------------------------
module swfc_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_stall,
   input logic                      rsp_valid,
   input logic                      rsp_stall,
   input swfc_pkg::rsp_payload_type rsp_data
);

   // a held result keeps its value
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   // no result right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // time fields stay in range
   a_time_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.minutes <= swfc_pkg::MINSEC_LAST &&
                    rsp_data.seconds <= swfc_pkg::MINSEC_LAST)
      else $error("time field out of range");

   // unused mode code never shows
   a_mode_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.count_mode == swfc_pkg::MODE_UP ||
                    rsp_data.count_mode == swfc_pkg::MODE_DOWN ||
                    rsp_data.count_mode == swfc_pkg::MODE_STOP)
      else $error("unused count mode");

   // input side only stalls while the result side is stalled
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled without output back-pressure");

endmodule

bind stopwatch_with_framed_commands swfc_checker u_swfc_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

FILE: tb/sv/stopwatch_with_framed_commands_test.sv
// ----------------------------------------------------------------------------
// stopwatch_with_framed_commands_test
// Self-checking bench for the hh:mm:ss stopwatch with framed commands.
// An opening script covers every event kind and command byte and three frame shapes.
// Random phases follow, each with its own countdown preset. Between phases
// the bench lets the block drain, then rewrites the preset registers. Each
// result is compared field by field with a model of the stopwatch that the
// bench keeps itself.
// ----------------------------------------------------------------------------
module stopwatch_with_framed_commands_test;
   timeunit 1ns;
   timeprecision 1ps;

   // request kinds the block does not define
   localparam logic [swfc_pkg::KIND_W-1:0] KIND_SPARE_FIRST = 3'd5;
   localparam logic [swfc_pkg::KIND_W-1:0] KIND_SPARE_LAST  = 3'd7;
   // register indexes past the defined ones
   localparam logic [swfc_pkg::CSR_IDX_W-1:0] CSR_FIRST_UNUSED = 8'd2;
   localparam logic [swfc_pkg::CSR_IDX_W-1:0] CSR_LAST_UNUSED  = 8'hFF;
   // byte positions inside a frame
   localparam logic [swfc_pkg::BYTE_W-1:0] POS_LENGTH  = 8'd1;
   localparam logic [swfc_pkg::BYTE_W-1:0] POS_COMMAND = 8'd2;

   localparam int  MAX_IDLE         = 17;
   localparam int  SETTLE_CYCLES    = 6;
   localparam int  PHASES           = 6;
   localparam int  EVENTS_PER_PHASE = 115;
   localparam int  SCRIPT_LEN       = 25;
   localparam longint RUN_LIMIT_NS  = 64'd3_000_000;

   typedef struct packed {
      logic [swfc_pkg::KIND_W-1:0] kind;
      logic [swfc_pkg::BYTE_W-1:0] data;
      logic                        typed;
      swfc_pkg::rsp_payload_type   want;
   } script_row_type;

   localparam swfc_pkg::rsp_payload_type NO_READING = '0;

   logic                           clock;
   logic                           reset     = 1'b1;
   logic                           req_valid = 1'b0;
   logic                           req_stall;
   swfc_pkg::req_payload_type      req_data  = '0;
   logic                           rsp_valid;
   logic                           rsp_stall = 1'b0;
   swfc_pkg::rsp_payload_type      rsp_data;
   logic                           csr_valid = 1'b0;
   logic                           csr_ready;
   logic [swfc_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [swfc_pkg::CSR_DAT_W-1:0] csr_wdata = '0;

   // model state of the stopwatch
   logic [swfc_pkg::HOURS_W-1:0]  clk_hours;
   logic [swfc_pkg::MINSEC_W-1:0] clk_minutes;
   logic [swfc_pkg::MINSEC_W-1:0] clk_seconds;
   logic [swfc_pkg::MODE_W-1:0]   clk_mode;
   logic                          tick_lamp;
   logic                          cmd_lamp;
   logic                          in_frame;
   logic [swfc_pkg::BYTE_W-1:0]   frame_pos;
   logic [swfc_pkg::BYTE_W-1:0]   frame_len;
   logic [swfc_pkg::BYTE_W-1:0]   frame_cmd;
   logic [swfc_pkg::MINSEC_W-1:0] preset_min;
   logic [swfc_pkg::MINSEC_W-1:0] preset_sec;

   swfc_pkg::rsp_payload_type awaited_readings [$];
   int                        mismatches      = 0;
   int                        readings_seen   = 0;
   bit                        req_quiet       = 1'b0;
   bit                        rsp_quiet       = 1'b0;

   // opening script: every kind, every command, three frame shapes
   script_row_type opening_script [SCRIPT_LEN] = '{
      '{swfc_pkg::KIND_TICK, 8'h00, 1'b1,
        '{8'd0, 6'd0, 6'd1, swfc_pkg::MODE_UP, 1'b1, 1'b0, 1'b0}},
      '{swfc_pkg::KIND_CONSOLE, swfc_pkg::CMD_LED, 1'b1,
        '{8'd0, 6'd0, 6'd1, swfc_pkg::MODE_UP, 1'b1, 1'b1, 1'b0}},
      '{swfc_pkg::KIND_CONSOLE, 8'hFF, 1'b1,
        '{8'd0, 6'd0, 6'd1, swfc_pkg::MODE_UP, 1'b1, 1'b1, 1'b0}},
      '{swfc_pkg::KIND_CONSOLE, swfc_pkg::CMD_DOWN, 1'b1,
        '{8'd0, 6'd2, 6'd59, swfc_pkg::MODE_DOWN, 1'b1, 1'b1, 1'b0}},
      '{swfc_pkg::KIND_TICK, 8'hFF, 1'b1,
        '{8'd0, 6'd2, 6'd58, swfc_pkg::MODE_DOWN, 1'b0, 1'b1, 1'b0}},
      '{KIND_SPARE_FIRST, 8'h00, 1'b1,
        '{8'd0, 6'd2, 6'd58, swfc_pkg::MODE_DOWN, 1'b0, 1'b1, 1'b0}},
      '{KIND_SPARE_LAST, 8'hFF, 1'b1,
        '{8'd0, 6'd2, 6'd58, swfc_pkg::MODE_DOWN, 1'b0, 1'b1, 1'b0}},
      '{swfc_pkg::KIND_RESET_BTN, 8'hFF, 1'b1,
        '{8'd0, 6'd0, 6'd0, swfc_pkg::MODE_UP, 1'b0, 1'b1, 1'b0}},
      '{swfc_pkg::KIND_TICK, 8'h55, 1'b0, NO_READING},
      '{swfc_pkg::KIND_DOWN_BTN, 8'h00, 1'b1,
        '{8'd0, 6'd2, 6'd59, swfc_pkg::MODE_DOWN, 1'b1, 1'b1, 1'b0}},
      '{swfc_pkg::KIND_CONSOLE, swfc_pkg::CMD_CLEAR, 1'b1,
        '{8'd0, 6'd0, 6'd0, swfc_pkg::MODE_UP, 1'b1, 1'b1, 1'b0}},
      '{swfc_pkg::KIND_CONSOLE, swfc_pkg::CMD_LED, 1'b1,
        '{8'd0, 6'd0, 6'd0, swfc_pkg::MODE_UP, 1'b1, 1'b0, 1'b0}},
      '{swfc_pkg::KIND_FRAME, 8'hFF, 1'b0, NO_READING},
      '{swfc_pkg::KIND_FRAME, 8'h03, 1'b0, NO_READING},
      '{swfc_pkg::KIND_FRAME, swfc_pkg::CMD_DOWN, 1'b1,
        '{8'd0, 6'd2, 6'd59, swfc_pkg::MODE_DOWN, 1'b1, 1'b0, 1'b1}},
      '{swfc_pkg::KIND_FRAME, 8'h00, 1'b0, NO_READING},
      '{swfc_pkg::KIND_FRAME, 8'h04, 1'b0, NO_READING},
      '{swfc_pkg::KIND_FRAME, swfc_pkg::CMD_LED, 1'b0, NO_READING},
      '{swfc_pkg::KIND_FRAME, 8'h00, 1'b1,
        '{8'd0, 6'd2, 6'd59, swfc_pkg::MODE_DOWN, 1'b1, 1'b0, 1'b1}},
      '{swfc_pkg::KIND_FRAME, 8'h55, 1'b0, NO_READING},
      '{swfc_pkg::KIND_TICK, 8'hAA, 1'b0, NO_READING},
      '{swfc_pkg::KIND_FRAME, 8'h05, 1'b0, NO_READING},
      '{swfc_pkg::KIND_FRAME, swfc_pkg::CMD_CLEAR, 1'b0, NO_READING},
      '{swfc_pkg::KIND_FRAME, 8'h80, 1'b0, NO_READING},
      '{swfc_pkg::KIND_FRAME, 8'h7F, 1'b1,
        '{8'd0, 6'd0, 6'd0, swfc_pkg::MODE_UP, 1'b0, 1'b0, 1'b1}}
   };

   stopwatch_with_framed_commands dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // run limit
   initial begin
      #(RUN_LIMIT_NS);
      $display("simulation failed");
      $finish;
   end

   // ---------------------------------------------------------------- model

   function automatic void zero_time();
      clk_hours   = '0;
      clk_minutes = '0;
      clk_seconds = '0;
      clk_mode    = swfc_pkg::MODE_UP;
   endfunction

   // preset values above 59 are clamped on load
   function automatic void start_countdown();
      clk_hours   = '0;
      clk_minutes = (preset_min > swfc_pkg::MINSEC_LAST) ? swfc_pkg::MINSEC_LAST : preset_min;
      clk_seconds = (preset_sec > swfc_pkg::MINSEC_LAST) ? swfc_pkg::MINSEC_LAST : preset_sec;
      clk_mode    = swfc_pkg::MODE_DOWN;
   endfunction

   function automatic void clear_model();
      zero_time();
      tick_lamp  = 1'b0;
      cmd_lamp   = 1'b0;
      in_frame   = 1'b0;
      frame_pos  = '0;
      frame_len  = '0;
      frame_cmd  = '0;
      preset_min = 6'd2;
      preset_sec = 6'd59;
   endfunction

   function automatic void advance_clock();
      tick_lamp = ~tick_lamp;
      case (clk_mode)
         swfc_pkg::MODE_UP: begin
            if (clk_seconds >= swfc_pkg::MINSEC_LAST) begin
               clk_seconds = '0;
               if (clk_minutes >= swfc_pkg::MINSEC_LAST) begin
                  clk_minutes = '0;
                  clk_hours   = clk_hours + 8'd1;
               end else begin
                  clk_minutes = clk_minutes + 6'd1;
               end
            end else begin
               clk_seconds = clk_seconds + 6'd1;
            end
         end
         swfc_pkg::MODE_DOWN: begin
            // a countdown already at 00:00 just stops
            if (clk_seconds != '0) begin
               clk_seconds = clk_seconds - 6'd1;
            end else if (clk_minutes != '0) begin
               clk_minutes = clk_minutes - 6'd1;
               clk_seconds = swfc_pkg::MINSEC_LAST;
            end
            if (clk_minutes == '0 && clk_seconds == '0) clk_mode = swfc_pkg::MODE_STOP;
         end
         default: ;
      endcase
   endfunction

   // frame bytes: opener, length, command, then filler up to the length
   function automatic logic take_frame_byte(input logic [swfc_pkg::BYTE_W-1:0] b);
      if (!in_frame) begin
         in_frame  = 1'b1;
         frame_pos = POS_LENGTH;
         return 1'b0;
      end
      if (frame_pos == POS_LENGTH) begin
         frame_len = b;
         frame_pos = POS_COMMAND;
         return 1'b0;
      end
      if (frame_pos == POS_COMMAND) frame_cmd = b;
      frame_pos = frame_pos + 8'd1;
      // lengths below three never match, so those frames run to the guard
      if (frame_pos == frame_len || frame_pos >= swfc_pkg::FRAME_MAX) begin
         in_frame  = 1'b0;
         frame_pos = '0;
         if (frame_cmd == swfc_pkg::CMD_CLEAR) zero_time();
         else if (frame_cmd == swfc_pkg::CMD_DOWN) start_countdown();
         return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic swfc_pkg::rsp_payload_type next_reading(
      input swfc_pkg::req_payload_type ev);
      swfc_pkg::rsp_payload_type shown;
      logic                      closed;
      closed = 1'b0;
      case (ev.req_type)
         swfc_pkg::KIND_TICK: advance_clock();
         swfc_pkg::KIND_CONSOLE: begin
            if (ev.data_byte == swfc_pkg::CMD_LED) cmd_lamp = ~cmd_lamp;
            else if (ev.data_byte == swfc_pkg::CMD_CLEAR) zero_time();
            else if (ev.data_byte == swfc_pkg::CMD_DOWN) start_countdown();
         end
         swfc_pkg::KIND_FRAME:     closed = take_frame_byte(ev.data_byte);
         swfc_pkg::KIND_RESET_BTN: zero_time();
         swfc_pkg::KIND_DOWN_BTN:  start_countdown();
         default: ;
      endcase
      shown.hours       = clk_hours;
      shown.minutes     = clk_minutes;
      shown.seconds     = clk_seconds;
      shown.count_mode  = clk_mode;
      shown.tick_led    = tick_lamp;
      shown.command_led = cmd_lamp;
      shown.frame_done  = closed;
      return shown;
   endfunction

   // ------------------------------------------------------------- checking

   task automatic report_mismatch(input string what);
      $display("mismatch at %0t ns: %s", $time, what);
      mismatches++;
   endtask

   task automatic compare_field(input string name, input logic [7:0] got,
                                input logic [7:0] want);
      if (got !== want)
         report_mismatch($sformatf("result %0d %s: got %0d, expected %0d",
                                   readings_seen, name, got, want));
   endtask

   task automatic check_reading(input swfc_pkg::rsp_payload_type got);
      swfc_pkg::rsp_payload_type want;
      if (awaited_readings.size() == 0) begin
         report_mismatch($sformatf("result %h with nothing expected", got));
         return;
      end
      want = awaited_readings.pop_front();
      compare_field("hours",       got.hours,           want.hours);
      compare_field("minutes",     8'(got.minutes),     8'(want.minutes));
      compare_field("seconds",     8'(got.seconds),     8'(want.seconds));
      compare_field("count_mode",  8'(got.count_mode),  8'(want.count_mode));
      compare_field("tick_led",    8'(got.tick_led),    8'(want.tick_led));
      compare_field("command_led", 8'(got.command_led), 8'(want.command_led));
      compare_field("frame_done",  8'(got.frame_done),  8'(want.frame_done));
      readings_seen++;
   endtask

   function automatic int idle_cycles(input bit quiet);
      return quiet ? 0 : int'($urandom_range(0, MAX_IDLE));
   endfunction

   // result side: random stall before each transfer
   initial begin : reading_sink
      int hold;
      wait (reset === 1'b0);
      forever begin
         hold = idle_cycles(rsp_quiet);
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(negedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
         while (rsp_valid !== 1'b1) @(posedge clock);
         check_reading(rsp_data);
         @(negedge clock);
      end
   end

   // ------------------------------------------------------------- stimulus

   function automatic logic [swfc_pkg::BYTE_W-1:0] any_byte();
      return 8'($urandom_range(0, 255));
   endfunction

   function automatic logic [swfc_pkg::BYTE_W-1:0] pick_command();
      case ($urandom_range(0, 3))
         0:       return swfc_pkg::CMD_CLEAR;
         1:       return swfc_pkg::CMD_DOWN;
         2:       return swfc_pkg::CMD_LED;
         default: return any_byte();
      endcase
   endfunction

   // one event transfer; returns in the step of the accepting edge
   task automatic send_event(input swfc_pkg::req_payload_type ev, input logic typed,
                             input swfc_pkg::rsp_payload_type want);
      swfc_pkg::rsp_payload_type model_out;
      int                        gap;
      gap = idle_cycles(req_quiet);
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= ev;
      @(posedge clock);
      while (req_stall !== 1'b0) @(posedge clock);
      model_out = next_reading(ev);
      awaited_readings.push_back(typed ? want : model_out);
   endtask

   task automatic send(input logic [swfc_pkg::KIND_W-1:0] kind,
                       input logic [swfc_pkg::BYTE_W-1:0] data);
      swfc_pkg::req_payload_type ev;
      ev.req_type  = kind;
      ev.data_byte = data;
      send_event(ev, 1'b0, NO_READING);
   endtask

   task automatic hold_off();
      @(negedge clock);
      req_valid <= 1'b0;
   endtask

   // sender pauses until every result is back and the pipe is empty
   task automatic wait_drained();
      while (awaited_readings.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [swfc_pkg::CSR_IDX_W-1:0] idx,
                            input logic [swfc_pkg::CSR_DAT_W-1:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      while (csr_ready !== 1'b1) @(posedge clock);
      case (idx)
         swfc_pkg::CSR_CD_MINUTES: preset_min = val[swfc_pkg::MINSEC_W-1:0];
         swfc_pkg::CSR_CD_SECONDS: preset_sec = val[swfc_pkg::MINSEC_W-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // frame with random content; some are cut short and merge into the next
   task automatic send_frame();
      logic [swfc_pkg::BYTE_W-1:0] len;
      int                          nbytes;
      case ($urandom_range(0, 3))
         0:       len = 8'($urandom_range(0, 2));
         1:       len = 8'($urandom_range(swfc_pkg::FRAME_MAX, 255));
         default: len = 8'($urandom_range(3, swfc_pkg::FRAME_MAX - 1));
      endcase
      nbytes = (len >= 3 && len < swfc_pkg::FRAME_MAX) ? int'(len)
                                                       : int'(swfc_pkg::FRAME_MAX);
      if ($urandom_range(0, 9) == 0) nbytes = int'($urandom_range(1, nbytes - 1));
      for (int i = 0; i < nbytes; i++) begin
         if ($urandom_range(0, 7) == 0) send(swfc_pkg::KIND_TICK, any_byte());
         if (i == POS_LENGTH) send(swfc_pkg::KIND_FRAME, len);
         else if (i == POS_COMMAND) send(swfc_pkg::KIND_FRAME, pick_command());
         else send(swfc_pkg::KIND_FRAME, any_byte());
      end
   endtask

   task automatic run_random(input int budget);
      int first;
      int pick;
      first = readings_seen + awaited_readings.size();
      while (readings_seen + awaited_readings.size() - first < budget) begin
         pick = $urandom_range(0, 99);
         if (pick < 40) begin
            send_frame();
         end else if (pick < 70) begin
            repeat ($urandom_range(1, 8)) send(swfc_pkg::KIND_TICK, any_byte());
         end else if (pick < 82) begin
            send(swfc_pkg::KIND_CONSOLE, pick_command());
         end else if (pick < 92) begin
            send($urandom_range(0, 1) ? swfc_pkg::KIND_RESET_BTN : swfc_pkg::KIND_DOWN_BTN,
                 any_byte());
         end else if (pick < 96) begin
            send(3'($urandom_range(KIND_SPARE_FIRST, KIND_SPARE_LAST)), any_byte());
         end else begin
            // stray frame byte
            send(swfc_pkg::KIND_FRAME, any_byte());
         end
      end
   endtask

   // ------------------------------------------------------------- main flow

   logic [swfc_pkg::CSR_DAT_W-1:0] preset_min_plan [PHASES] =
      '{8'h00, 8'hFF, 8'd59, 8'd0, 8'd1, 8'h00};
   logic [swfc_pkg::CSR_DAT_W-1:0] preset_sec_plan [PHASES] =
      '{8'h00, 8'hFF, 8'd59, 8'd1, 8'd0, 8'h00};

   initial begin : stimulus
      swfc_pkg::req_payload_type      ev;
      logic [swfc_pkg::CSR_DAT_W-1:0] mins;
      logic [swfc_pkg::CSR_DAT_W-1:0] secs;
      logic [swfc_pkg::CSR_IDX_W-1:0] spare_idx;

      clear_model();
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // opening script with the reset preset
      foreach (opening_script[i]) begin
         ev.req_type  = opening_script[i].kind;
         ev.data_byte = opening_script[i].data;
         send_event(ev, opening_script[i].typed, opening_script[i].want);
      end
      hold_off();
      wait_drained();

      for (int p = 0; p < PHASES; p++) begin
         mins      = preset_min_plan[p];
         secs      = preset_sec_plan[p];
         spare_idx = (p == 1) ? CSR_LAST_UNUSED
                              : 8'($urandom_range(CSR_FIRST_UNUSED, CSR_LAST_UNUSED));
         if (p == PHASES - 1) begin
            mins = any_byte();
            secs = any_byte();
         end
         write_csr(swfc_pkg::CSR_CD_MINUTES, mins);
         write_csr(spare_idx, any_byte());
         write_csr(swfc_pkg::CSR_CD_SECONDS, secs);

         req_quiet = ($urandom_range(0, 3) == 0);
         rsp_quiet = ($urandom_range(0, 3) == 0);

         // start a countdown from the new preset and run it a little
         send(swfc_pkg::KIND_DOWN_BTN, any_byte());
         send(swfc_pkg::KIND_TICK, any_byte());
         send(swfc_pkg::KIND_TICK, any_byte());
         run_random(EVENTS_PER_PHASE);
         hold_off();
         wait_drained();
      end

      if (mismatches == 0) $display("simulation ok");
      else $display("simulation failed");
      $finish;
   end

endmodule
